// ----- hw/rtl/bpa_pkg.sv -----
// ----------------------------------------------------------------------------
// bpa_pkg: shared types and constants
// Field widths, action and status codes, sequencer states and the control
// structs passed to the row unit of the bitmap page allocator.
// ----------------------------------------------------------------------------
`default_nettype none

package bpa_pkg;

  localparam int ACT_W    = 2;
  localparam int ADDR_W   = 28;
  localparam int LEN_W    = 29;
  localparam int STAT_W   = 2;

  // One map row holds the used bits of this many pages.
  localparam int WORD_BITS = 32;
  localparam int BIT_W     = $clog2(WORD_BITS);

  typedef enum logic [ACT_W-1:0] {
    ACT_LOAD  = 2'd0,
    ACT_ALLOC = 2'd1,
    ACT_FREE  = 2'd2
  } action_t;

  typedef enum logic [STAT_W-1:0] {
    STAT_OK    = 2'd0,
    STAT_NONE  = 2'd1,
    STAT_RANGE = 2'd2
  } status_t;

  typedef enum logic [3:0] {
    S_INIT,
    S_IDLE,
    S_SETUP,
    S_REG_CHK,
    S_CLR_RD,
    S_CLR_WR,
    S_ALC_RD,
    S_ALC_CHK,
    S_DONE
  } state_t;

  typedef enum logic {
    ROP_CLEAR,
    ROP_TAKE
  } row_op_t;

  typedef struct packed {
    row_op_t          op;
    logic [BIT_W-1:0] lo;
    logic [BIT_W-1:0] hi;
  } row_ctl_t;

  typedef struct packed {
    logic             found;
    logic [BIT_W-1:0] idx;
  } row_res_t;

endpackage

`default_nettype wire

// ----- hw/rtl/bpa_ifs.sv -----
// ----------------------------------------------------------------------------
// bpa_ifs: request and response channels
// Valid/ready channels carrying one allocator request item and one response
// item.
// ----------------------------------------------------------------------------
`default_nettype none

interface bpa_req_if;
  import bpa_pkg::*;

  logic                valid;
  logic                ready;
  logic [ACT_W-1:0]    action;
  logic                region_usable;
  logic [ADDR_W-1:0]   byte_address;
  logic [LEN_W-1:0]    region_length;

  modport source (output valid, output action, output region_usable,
                  output byte_address, output region_length, input ready);
  modport sink   (input valid, input action, input region_usable,
                  input byte_address, input region_length, output ready);
endinterface

interface bpa_rsp_if;
  import bpa_pkg::*;

  logic                valid;
  logic                ready;
  logic [ADDR_W-1:0]   page_address;
  logic [STAT_W-1:0]   status;

  modport source (output valid, output page_address, output status, input ready);
  modport sink   (input valid, input page_address, input status, output ready);
endinterface

`default_nettype wire

// ----- hw/rtl/bpa_map_ram.sv -----
// ----------------------------------------------------------------------------
// bpa_map_ram: page map storage
// One row of used bits per address, one write and one registered read port.
// ----------------------------------------------------------------------------
`default_nettype none

module bpa_map_ram #(
  parameter int ROWS  = 2048,
  parameter int ROW_W = 11
) (
  input  wire logic                          clk,
  input  wire logic                          we,
  input  wire logic [ROW_W-1:0]              waddr,
  input  wire logic [bpa_pkg::WORD_BITS-1:0] wdata,
  input  wire logic                          re,
  input  wire logic [ROW_W-1:0]              raddr,
  output logic      [bpa_pkg::WORD_BITS-1:0] rdata
);
  import bpa_pkg::*;

  logic [WORD_BITS-1:0] mem [ROWS];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

// ----- hw/rtl/bpa_row_unit.sv -----
// ----------------------------------------------------------------------------
// bpa_row_unit: shared row modify unit
// Clears a window of bits in a map row, or finds the lowest free bit inside
// the window and marks it used.
// ----------------------------------------------------------------------------
`default_nettype none

module bpa_row_unit (
  input  wire logic [bpa_pkg::WORD_BITS-1:0] data,
  input  wire bpa_pkg::row_ctl_t             ctl,
  output logic      [bpa_pkg::WORD_BITS-1:0] new_data,
  output bpa_pkg::row_res_t                  res
);
  import bpa_pkg::*;

  logic [WORD_BITS-1:0] win;
  logic [WORD_BITS-1:0] cand;
  logic [WORD_BITS-1:0] pick;

  // Window of bit positions lo..hi inclusive.
  always_comb begin
    for (int b = 0; b < WORD_BITS; b++) begin
      win[b] = (BIT_W'(b) >= ctl.lo) && (BIT_W'(b) <= ctl.hi);
    end
  end

  assign cand = ~data & win;

  // Lowest free bit in the window.
  always_comb begin
    res.found = |cand;
    res.idx   = '0;
    for (int b = WORD_BITS - 1; b >= 0; b--) begin
      if (cand[b]) begin
        res.idx = BIT_W'(b);
      end
    end
  end

  assign pick = res.found ? (WORD_BITS'(1) << res.idx) : '0;

  always_comb begin
    unique case (ctl.op)
      ROP_CLEAR: new_data = data & ~win;
      ROP_TAKE:  new_data = data | pick;
      default:   new_data = data;
    endcase
  end

endmodule

`default_nettype wire

// ----- hw/rtl/bitmap_page_allocator_core.sv -----
// ----------------------------------------------------------------------------
// bitmap_page_allocator_core: physical page allocator over a used-bit map
// Sequencer walking the page map one row at a time through a shared row unit.
// ----------------------------------------------------------------------------
// Usage:
//   req carries one item: action (load region, allocate, free), the region
//   usable flag, a byte address and a region length. rsp returns one item for
//   every request: the allocated page's byte address and a status code.
//   The map is stored as rows of 32 used bits in a single-port-read memory.
//   After rst a clearing pass writes every row, ROWS = NUM_PAGES/32 rows
//   (2048 at the defaults), to all ones (every page used); req.ready stays
//   low until it ends. The allocation limit resets to zero.
//   Steps per item, up to loading the response register: free: setup, then
//   a read and a write-back of the page's row (none if beyond the map); load
//   region: setup, a region check, then a read and a write-back per map row
//   touched (no check if not usable, no rows if empty); allocate: setup, then
//   a read and a check per row scanned up to the row holding the free page,
//   or up to the allocation limit when none is free.
//   The row loop (read a row, then check or modify it) sets how long an item takes.
//   One item is in flight at a time. The response sits in an output register;
//   a new request is taken while it waits, and the sequencer holds its next
//   result until rsp.ready frees the register.
// ----------------------------------------------------------------------------
`default_nettype none

module bitmap_page_allocator_core #(
  parameter int NUM_PAGES  = 65536,
  parameter int PAGE_BYTES = 4096
) (
  input  wire logic clk,
  input  wire logic rst,
  bpa_req_if.sink   req,
  bpa_rsp_if.source rsp
);
  import bpa_pkg::*;

  localparam int PB_SHIFT = $clog2(PAGE_BYTES);
  localparam int ROWS     = (NUM_PAGES + WORD_BITS - 1) / WORD_BITS;
  localparam int ROW_W    = (ROWS > 1) ? $clog2(ROWS) : 1;
  localparam int ROWC_W   = ROW_W + 1;
  localparam int PG_W     = ROW_W + BIT_W;
  localparam int LIM_W    = $clog2(NUM_PAGES + 1);
  localparam int SUM_W    = ADDR_W + 2;
  localparam int RAW_W    = SUM_W - PB_SHIFT;
  localparam int CMP_W    = 32;
  localparam int AB_W     = PG_W + PB_SHIFT;

  localparam logic [SUM_W-1:0]  PB_M1       = SUM_W'(PAGE_BYTES - 1);
  localparam logic [CMP_W-1:0]  NUM_PAGES_C = CMP_W'(NUM_PAGES);
  localparam logic [ROWC_W-1:0] LAST_ROW    = ROWC_W'(ROWS - 1);
  localparam logic [ADDR_W-1:0] ALIGN_MASK  = ADDR_W'(PAGE_BYTES - 1);

  // Sequencer and working registers
  state_t             state;
  state_t             state_next;
  logic [ROWC_W-1:0]  row;
  action_t            act;
  logic               usable;
  logic [ADDR_W-1:0]  addr_q;
  logic [LEN_W-1:0]   len_q;
  logic [RAW_W-1:0]   raw_first;
  logic [RAW_W-1:0]   raw_end;
  logic [PG_W-1:0]    first_pg;
  logic [PG_W-1:0]    last_pg;
  logic [LIM_W-1:0]   page_limit;
  status_t            res_status;
  logic [ADDR_W-1:0]  res_addr;

  // Map memory and row unit hookup
  logic                 mem_we;
  logic                 mem_re;
  logic [WORD_BITS-1:0] mem_wdata;
  logic [WORD_BITS-1:0] mem_wdata_unit;
  logic [WORD_BITS-1:0] mem_rdata;
  logic [WORD_BITS-1:0] unit_data;
  row_ctl_t             unit_ctl;
  row_res_t             unit_res;

  // Address arithmetic
  logic [SUM_W-1:0]  sum_first;
  logic [SUM_W-1:0]  sum_end;
  logic [CMP_W-1:0]  raw_first_c;
  logic [CMP_W-1:0]  raw_end_c;
  logic              end_over;
  logic [CMP_W-1:0]  end_clip_c;
  logic [CMP_W-1:0]  free_pg_c;
  logic              free_over;
  logic [CMP_W-1:0]  limit_c;
  logic [CMP_W-1:0]  lim_last_c;
  logic [CMP_W-1:0]  row_base_c;
  logic [ROW_W-1:0]  cur_row;
  logic              at_first;
  logic              at_last;
  logic              lim_row_hit;
  logic              scan_end;
  logic [PG_W-1:0]   alloc_pg;
  logic [AB_W-1:0]   alloc_byte;
  logic              out_free;

  // Round the region base up and its end down to whole pages.
  assign sum_first   = {2'b00, addr_q} + PB_M1;
  assign sum_end     = {2'b00, addr_q} + {1'b0, len_q};
  assign raw_first_c = CMP_W'(raw_first);
  assign raw_end_c   = CMP_W'(raw_end);
  assign end_over    = raw_end_c > NUM_PAGES_C;
  assign end_clip_c  = end_over ? NUM_PAGES_C : raw_end_c;

  assign free_pg_c   = CMP_W'(addr_q >> PB_SHIFT);
  assign free_over   = free_pg_c >= NUM_PAGES_C;

  assign limit_c     = CMP_W'(page_limit);
  assign lim_last_c  = limit_c - CMP_W'(1);
  assign row_base_c  = CMP_W'(row) << BIT_W;
  assign cur_row     = row[ROW_W-1:0];

  assign at_first    = row == {1'b0, first_pg[PG_W-1:BIT_W]};
  assign at_last     = row == {1'b0, last_pg[PG_W-1:BIT_W]};
  assign lim_row_hit = CMP_W'(row) == (lim_last_c >> BIT_W);
  assign scan_end    = row_base_c >= limit_c;

  assign alloc_pg    = {cur_row, unit_res.idx};
  assign alloc_byte  = AB_W'(alloc_pg) << PB_SHIFT;

  assign out_free    = !rsp.valid || rsp.ready;

  assign req.ready   = (state == S_IDLE);

  // Row unit control: clear a window on load and free, take a bit on allocate.
  always_comb begin
    unit_ctl.op = ROP_CLEAR;
    unit_ctl.lo = '0;
    unit_ctl.hi = '1;
    if (state == S_CLR_WR) begin
      unit_ctl.lo = at_first ? first_pg[BIT_W-1:0] : '0;
      unit_ctl.hi = at_last ? last_pg[BIT_W-1:0] : '1;
    end else if (state == S_ALC_CHK) begin
      unit_ctl.op = ROP_TAKE;
      unit_ctl.hi = lim_row_hit ? lim_last_c[BIT_W-1:0] : '1;
    end
  end

  assign unit_data = mem_rdata;
  assign mem_re    = (state == S_CLR_RD) || (state == S_ALC_RD);
  assign mem_we    = (state == S_INIT) || (state == S_CLR_WR) ||
                     ((state == S_ALC_CHK) && unit_res.found);

  bpa_row_unit u_row (
    .data     (unit_data),
    .ctl      (unit_ctl),
    .new_data (mem_wdata_unit),
    .res      (unit_res)
  );

  // The clearing pass fills each row with all ones.
  assign mem_wdata = (state == S_INIT) ? '1 : mem_wdata_unit;

  bpa_map_ram #(
    .ROWS  (ROWS),
    .ROW_W (ROW_W)
  ) u_map (
    .clk   (clk),
    .we    (mem_we),
    .waddr (cur_row),
    .wdata (mem_wdata),
    .re    (mem_re),
    .raddr (cur_row),
    .rdata (mem_rdata)
  );

  // State register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_INIT;
    end else begin
      state <= state_next;
    end
  end

  // Next state
  always_comb begin
    state_next = state;
    unique case (state)
      S_INIT: begin
        if (row == LAST_ROW) state_next = S_IDLE;
      end
      S_IDLE: begin
        if (req.valid) state_next = S_SETUP;
      end
      S_SETUP: begin
        unique case (act)
          ACT_LOAD:  state_next = usable ? S_REG_CHK : S_DONE;
          ACT_ALLOC: state_next = S_ALC_RD;
          ACT_FREE:  state_next = free_over ? S_DONE : S_CLR_RD;
          default:   state_next = S_DONE;
        endcase
      end
      S_REG_CHK: begin
        state_next = (raw_first_c < end_clip_c) ? S_CLR_RD : S_DONE;
      end
      S_CLR_RD: begin
        state_next = S_CLR_WR;
      end
      S_CLR_WR: begin
        state_next = at_last ? S_DONE : S_CLR_RD;
      end
      S_ALC_RD: begin
        state_next = scan_end ? S_DONE : S_ALC_CHK;
      end
      S_ALC_CHK: begin
        state_next = unit_res.found ? S_DONE : S_ALC_RD;
      end
      S_DONE: begin
        if (out_free) state_next = S_IDLE;
      end
      default: begin
        state_next = S_INIT;
      end
    endcase
  end

  // Working registers and response register
  always_ff @(posedge clk) begin
    if (rst) begin
      row        <= '0;
      page_limit <= '0;
      rsp.valid  <= 1'b0;
    end else begin
      // Drop the taken response unless the next one loads in this cycle.
      if (rsp.valid && rsp.ready && state != S_DONE) begin
        rsp.valid <= 1'b0;
      end
      unique case (state)
        S_INIT: begin
          row <= row + 1'b1;
        end
        S_IDLE: begin
          if (req.valid) begin
            act        <= action_t'(req.action);
            usable     <= req.region_usable;
            addr_q     <= req.byte_address;
            len_q      <= req.region_length;
            res_status <= STAT_OK;
            res_addr   <= '0;
          end
        end
        S_SETUP: begin
          raw_first <= sum_first[SUM_W-1:PB_SHIFT];
          raw_end   <= sum_end[SUM_W-1:PB_SHIFT];
          if (act == ACT_FREE) begin
            // A free clears a one-page window; beyond the map, drop it.
            first_pg <= PG_W'(free_pg_c);
            last_pg  <= PG_W'(free_pg_c);
            row      <= ROWC_W'(free_pg_c >> BIT_W);
            if (free_over) res_status <= STAT_RANGE;
          end else if (act == ACT_ALLOC) begin
            row <= '0;
          end
        end
        S_REG_CHK: begin
          // Clip at the map end, raise the limit, set up the row walk.
          if (end_over) res_status <= STAT_RANGE;
          if (end_clip_c > limit_c) page_limit <= LIM_W'(end_clip_c);
          first_pg <= PG_W'(raw_first_c);
          last_pg  <= PG_W'(end_clip_c - CMP_W'(1));
          row      <= ROWC_W'(raw_first_c >> BIT_W);
        end
        S_CLR_WR: begin
          row <= row + 1'b1;
        end
        S_ALC_RD: begin
          if (scan_end) res_status <= STAT_NONE;
        end
        S_ALC_CHK: begin
          if (unit_res.found) begin
            res_addr <= ADDR_W'(alloc_byte);
          end else begin
            row <= row + 1'b1;
          end
        end
        S_DONE: begin
          if (out_free) begin
            rsp.valid        <= 1'b1;
            rsp.page_address <= res_addr;
            rsp.status       <= res_status;
          end
        end
        default: begin
        end
      endcase
    end
  end

  // Assertions
  assert property (@(posedge clk) disable iff (rst)
    (req.valid && req.ready) |=> !req.ready)
    else $error("request taken while an item is in flight");

  assert property (@(posedge clk) disable iff (rst)
    limit_c <= NUM_PAGES_C)
    else $error("allocation limit beyond the map");

  assert property (@(posedge clk) disable iff (rst)
    (rsp.valid && rsp.status == STAT_OK) |-> ((rsp.page_address & ALIGN_MASK) == '0))
    else $error("allocated address not page aligned");

  assert property (@(posedge clk) disable iff (rst)
    (rsp.valid && rsp.status != STAT_OK) |-> (rsp.page_address == '0))
    else $error("failed item carries a nonzero address");

  assert property (@(posedge clk) disable iff (rst)
    (state == S_IDLE || state == S_DONE) |-> !mem_we)
    else $error("map written outside an item");

endmodule

`default_nettype wire

// ----- test/tb_bitmap_page_allocator_core.sv -----
// ----------------------------------------------------------------------------
// tb_bitmap_page_allocator_core: self-checking bench for the page allocator
// Drives load-region, allocate, free and reserved-action requests through the request channel
// and checks every response. The bench keeps its own page map and limit,
// computes the response of each request when it is accepted, and compares it
// field by field with what the block returns. A directed run of corner cases
// comes first. Random traffic follows, mostly small regions and low frees.
// Random idle cycles are inserted on both channels.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_bitmap_page_allocator_core;
  import bpa_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int NUM_PAGES    = 65536;
  localparam int PAGE_BYTES   = 4096;
  localparam int RANDOM_ITEMS = 900;
  localparam int DRAIN_CYCLES = 20;

  // The package names three actions; the fourth encoding must be ignored.
  localparam logic [ACT_W-1:0] ACT_RESERVED = 2'd3;

  typedef struct {
    logic [ACT_W-1:0]  action;
    logic              region_usable;
    logic [ADDR_W-1:0] byte_address;
    logic [LEN_W-1:0]  region_length;
    int unsigned       hold_off;      // idle cycles before the item is offered
  } alloc_req_t;

  typedef struct {
    logic [ADDR_W-1:0] page_address;
    status_t           status;
  } alloc_rsp_t;

  logic clk;
  logic rst;

  bpa_req_if req_ch ();
  bpa_rsp_if rsp_ch ();

  bitmap_page_allocator_core #(
    .NUM_PAGES  (NUM_PAGES),
    .PAGE_BYTES (PAGE_BYTES)
  ) dut (
    .clk (clk),
    .rst (rst),
    .req (req_ch),
    .rsp (rsp_ch)
  );

  // Shadow copy of the allocator state: one used bit per page and the limit.
  bit          page_used [NUM_PAGES];
  int unsigned page_limit;

  alloc_req_t  request_q [$];
  alloc_rsp_t  owed_rsp_q [$];
  int unsigned total_items;
  int unsigned num_accepted;
  int unsigned num_returned;
  int unsigned mismatches;

  // Apply one request to the shadow map and return the response it earns.
  function automatic alloc_rsp_t page_map_step(alloc_req_t r);
    alloc_rsp_t      o;
    longint unsigned base;
    longint unsigned first_pg;
    longint unsigned end_pg;
    longint unsigned pg;
    bit              found;
    o.page_address = '0;
    o.status       = STAT_OK;
    base = 64'(r.byte_address);
    case (r.action)
      ACT_LOAD: begin
        if (r.region_usable) begin
          // Only whole pages: round the base up and the end down.
          first_pg = (base + PAGE_BYTES - 1) / PAGE_BYTES;
          end_pg   = (base + 64'(r.region_length)) / PAGE_BYTES;
          if (end_pg > NUM_PAGES) begin
            end_pg   = NUM_PAGES;
            o.status = STAT_RANGE;
          end
          for (pg = first_pg; pg < end_pg; pg++) page_used[pg] = 1'b0;
          // The limit only ever grows, even for an empty region.
          if (end_pg > page_limit) page_limit = 32'(end_pg);
        end
      end
      ACT_ALLOC: begin
        found = 1'b0;
        pg    = 0;
        while (!found && pg < page_limit) begin
          if (!page_used[pg]) begin
            page_used[pg]  = 1'b1;
            o.page_address = ADDR_W'(pg * PAGE_BYTES);
            found          = 1'b1;
          end
          pg++;
        end
        if (!found) o.status = STAT_NONE;
      end
      ACT_FREE: begin
        // The page holding the address is cleared, whatever its state or limit.
        pg = base / PAGE_BYTES;
        if (pg >= NUM_PAGES) o.status = STAT_RANGE;
        else page_used[pg] = 1'b0;
      end
      default: ;
    endcase
    return o;
  endfunction

  // Append one request; every fourth stretch of 40 items goes back to back.
  function automatic void queue_request(logic [ACT_W-1:0] action, logic usable,
                                        logic [ADDR_W-1:0] addr,
                                        logic [LEN_W-1:0] len);
    alloc_req_t r;
    r.action        = action;
    r.region_usable = usable;
    r.byte_address  = addr;
    r.region_length = len;
    r.hold_off      = ((request_q.size() / 40) % 4 == 3) ? 0 : $urandom_range(0, 7);
    request_q.push_back(r);
  endfunction

  // Clock: 12 ns period.
  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // Reset once, at the start of the run.
  initial begin
    rst = 1'b1;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
  end

  // Request driver: honor each item's hold-off, hold the item until accepted,
  // and update the shadow map on the edge where the handshake completes.
  alloc_req_t  on_bus;
  alloc_req_t  next_req;
  bit          have_next;
  int unsigned idle_left;

  always @(posedge clk) begin
    if (rst) begin
      req_ch.valid         <= 1'b0;
      req_ch.action        <= '0;
      req_ch.region_usable <= 1'b0;
      req_ch.byte_address  <= '0;
      req_ch.region_length <= '0;
      have_next = 1'b0;
      idle_left = 0;
    end else begin
      if (req_ch.valid && req_ch.ready) begin
        owed_rsp_q.push_back(page_map_step(on_bus));
        num_accepted++;
      end
      // Advance only when the bus is free or its item was just taken.
      if (!req_ch.valid || req_ch.ready) begin
        if (!have_next && request_q.size() != 0) begin
          next_req  = request_q.pop_front();
          idle_left = next_req.hold_off;
          have_next = 1'b1;
        end
        if (have_next && idle_left == 0) begin
          req_ch.valid         <= 1'b1;
          req_ch.action        <= next_req.action;
          req_ch.region_usable <= next_req.region_usable;
          req_ch.byte_address  <= next_req.byte_address;
          req_ch.region_length <= next_req.region_length;
          on_bus    = next_req;
          have_next = 1'b0;
        end else begin
          req_ch.valid <= 1'b0;
          if (have_next) idle_left--;
        end
      end
    end
  end

  // Response monitor: check each taken item against the oldest owed response,
  // then drop ready for a random stall before the next one.
  alloc_rsp_t  want;
  int unsigned stall_left;
  int unsigned stall_draw;

  always @(posedge clk) begin
    if (rst) begin
      rsp_ch.ready <= 1'b0;
      stall_left = 0;
    end else if (rsp_ch.valid && rsp_ch.ready) begin
      if (owed_rsp_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected response: page_address %h status %0d",
                   rsp_ch.page_address, rsp_ch.status);
      end else begin
        want = owed_rsp_q.pop_front();
        if (rsp_ch.page_address !== want.page_address || rsp_ch.status !== want.status) begin
          mismatches++;
          if (mismatches <= 10)
            $display("response %0d: page_address %h status %0d, want %h %0d",
                     num_returned, rsp_ch.page_address, rsp_ch.status,
                     want.page_address, want.status);
        end
      end
      num_returned++;
      stall_draw   = ((num_returned / 40) % 4 == 1) ? 0 : $urandom_range(0, 7);
      stall_left   = stall_draw;
      rsp_ch.ready <= (stall_draw == 0);
    end else if (stall_left != 0) begin
      stall_left--;
      rsp_ch.ready <= (stall_left == 0);
    end else begin
      rsp_ch.ready <= 1'b1;
    end
  end

  // Stimulus and end of run.
  int unsigned pick;

  initial begin
    foreach (page_used[i]) page_used[i] = 1'b1;
    page_limit   = 0;
    num_accepted = 0;
    num_returned = 0;
    mismatches   = 0;

    // Directed: empty limit, partial pages, empty region, unaligned and
    // repeated frees, regions past the map, the reserved action, full scans.
    queue_request(ACT_ALLOC, 1'b0, '0, '0);                     // limit still zero
    queue_request(ACT_FREE, 1'b0, 28'h0005000, '0);             // free above the limit
    queue_request(ACT_ALLOC, 1'b0, '0, '0);
    queue_request(ACT_LOAD, 1'b0, '0, 29'h0010000);             // unusable region
    queue_request(ACT_ALLOC, 1'b0, '0, '0);
    queue_request(ACT_LOAD, 1'b1, 28'h0000800, 29'h0002900);    // partial first and last
    queue_request(ACT_ALLOC, 1'b0, '0, '0);
    queue_request(ACT_ALLOC, 1'b0, '0, '0);
    queue_request(ACT_ALLOC, 1'b0, '0, '0);                     // pool exhausted
    queue_request(ACT_LOAD, 1'b1, 28'h0009000, '0);             // empty, raises limit
    queue_request(ACT_ALLOC, 1'b0, '0, '0);
    queue_request(ACT_FREE, 1'b0, 28'h0001234, '0);             // unaligned
    queue_request(ACT_FREE, 1'b0, 28'h0001FFF, '0);             // already free
    queue_request(ACT_ALLOC, 1'b0, '0, '0);
    queue_request(ACT_LOAD, 1'b1, 28'hFFFF000, 29'h0003000);    // runs past the map
    queue_request(ACT_LOAD, 1'b1, 28'hFFFFFFF, 29'h1FFFFFFF);   // starts past the last page
    queue_request(ACT_LOAD, 1'b0, 28'hFFFFFFF, 29'h1FFFFFFF);
    queue_request(ACT_RESERVED, 1'b1, 28'hFFFFFFF, 29'h1FFFFFFF);
    queue_request(ACT_FREE, 1'b1, 28'hFFFFFFF, 29'h1FFFFFFF);   // last page
    queue_request(ACT_ALLOC, 1'b0, '0, '0);                     // long scan
    queue_request(ACT_ALLOC, 1'b0, '0, '0);                     // full scan, none free
    queue_request(ACT_LOAD, 1'b1, '0, 29'h0040000);
    queue_request(ACT_ALLOC, 1'b0, '0, '0);
    queue_request(ACT_FREE, 1'b0, '0, '0);

    // Random: keep free pages low so scans stay short; a few huge regions
    // reach every address and length bit and refill the whole map.
    repeat (RANDOM_ITEMS) begin
      pick = $urandom_range(0, 99);
      if (pick < 40)
        queue_request(ACT_ALLOC, 1'($urandom), ADDR_W'($urandom), LEN_W'($urandom));
      else if (pick < 65)
        queue_request(ACT_FREE, 1'($urandom),
                      (pick < 60) ? ADDR_W'($urandom_range(0, 512 * PAGE_BYTES - 1))
                                  : ADDR_W'($urandom),
                      LEN_W'($urandom));
      else if (pick < 87)
        queue_request(ACT_LOAD, 1'b1, ADDR_W'($urandom_range(0, 1024 * PAGE_BYTES)),
                      LEN_W'($urandom_range(0, 64 * PAGE_BYTES)));
      else if (pick < 91)
        queue_request(ACT_LOAD, 1'b1, ADDR_W'($urandom), LEN_W'($urandom));
      else if (pick < 96)
        queue_request(ACT_LOAD, 1'b0, ADDR_W'($urandom), LEN_W'($urandom));
      else
        queue_request(ACT_RESERVED, 1'($urandom), ADDR_W'($urandom), LEN_W'($urandom));
    end
    total_items = request_q.size();

    // Wait for every item to be taken and answered, then let stragglers show.
    @(negedge rst);
    while (num_accepted != total_items || owed_rsp_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

  // Watchdog: far beyond a run where every item scans the whole map.
  initial begin
    #250ms;
    $display("Test completed with failures");
    $finish;
  end

endmodule

`default_nettype wire

// ----- files.f -----
hw/rtl/bpa_pkg.sv
hw/rtl/bpa_ifs.sv
hw/rtl/bpa_map_ram.sv
hw/rtl/bpa_row_unit.sv
hw/rtl/bitmap_page_allocator_core.sv
test/tb_bitmap_page_allocator_core.sv
